/* rtl/mmm_pkg.sv */
// Shared types and constants of the MDIO management master.
// Holds the request and result payload structs, command codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mmm_pkg;

  localparam int FRAME_BITS = 32;
  localparam int EVENT_DONE_BIT = 23;
  localparam int CFG_DATA_W = 6;
  localparam int DIV_W = 6;
  localparam int HOLD_W = 3;
  localparam int IDX_W = 7;

  localparam logic [1:0] REQ_READ = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_TICK = 2'd2;

  localparam logic SEL_FRAME = 1'b0;
  localparam logic SEL_EVENT = 1'b1;

  localparam logic CFG_MDC_DIVIDER = 1'b0;
  localparam logic CFG_HOLD_TICKS = 1'b1;

  localparam logic [1:0] OPCODE_READ = 2'b10;

  typedef logic [2:0] op_t;
  localparam op_t OP_NOP = 3'd0;
  localparam op_t OP_RD_FRAME = 3'd1;
  localparam op_t OP_RD_EVENT = 3'd2;
  localparam op_t OP_WR_FRAME = 3'd3;
  localparam op_t OP_CLR_EVENT = 3'd4;
  localparam op_t OP_TICK = 3'd5;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        reg_select;
    logic [31:0] write_data;
    logic        mdio_in;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        mdc_level;
    logic        mdio_drive;
    logic        mdio_enable;
    logic        done_event;
    logic        busy_flag;
  } out_item_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] data;
    logic        mdio_in;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/mmm_fifo.sv */
// Small register-based first-in first-out queue of generic width and depth.
// Used for the command queue and the result queue; no package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mmm_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wr_data,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rd_data,
  output logic                  empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule

`default_nettype wire

/* rtl/mmm_front.sv */
// Request classifier of the MDIO management master.
// Turns a bus request into an execution command; depends on mmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmm_front (
  input  wire mmm_pkg::in_item_t item,
  output mmm_pkg::cmd_t          cmd
);
  import mmm_pkg::*;

  always_comb begin
    cmd.data = item.write_data;
    cmd.mdio_in = item.mdio_in;
    case (item.req_type)
      REQ_READ: begin
        cmd.op = (item.reg_select == SEL_EVENT) ? OP_RD_EVENT : OP_RD_FRAME;
      end
      REQ_WRITE: begin
        if (item.reg_select == SEL_FRAME) begin
          cmd.op = OP_WR_FRAME;
        end else if (item.write_data[EVENT_DONE_BIT]) begin
          cmd.op = OP_CLR_EVENT;
        end else begin
          cmd.op = OP_NOP;
        end
      end
      REQ_TICK: begin
        cmd.op = OP_TICK;
      end
      default: begin
        cmd.op = OP_NOP;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/mmm_back.sv */
// Execution stage of the MDIO management master: registers, MDC divider and frame shifter.
// Runs one command per cycle while the result queue is not full, and builds its result; depends on mmm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mmm_back #(
  parameter int PREAMBLE_BITS = 32
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_wr_en,
  input  wire logic                            cfg_index,
  input  wire logic [mmm_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                            cmd_valid,
  input  wire mmm_pkg::cmd_t                   cmd,
  output logic                                 cmd_pop,
  input  wire logic                            res_full,
  output logic                                 res_push,
  output mmm_pkg::out_item_t                   res
);
  import mmm_pkg::*;

  localparam logic [IDX_W-1:0] PRE_IDX = IDX_W'(PREAMBLE_BITS);
  localparam logic [IDX_W:0] END_IDX = (IDX_W + 1)'(PREAMBLE_BITS + FRAME_BITS);

  logic [DIV_W-1:0]  mdc_divider_r;
  logic [HOLD_W-1:0] hold_ticks_r;

  logic [31:0]       frame_word_r, frame_word_nxt;
  logic [31:0]       shift_word_r, shift_word_nxt;
  logic [IDX_W-1:0]  bit_index_r, bit_index_nxt;
  logic [IDX_W-1:0]  clock_count_r, clock_count_nxt;
  logic [HOLD_W-1:0] hold_count_r, hold_count_nxt;
  logic              mdc_state_r, mdc_state_nxt;
  logic              line_out_r, line_out_nxt;
  logic              event_done_r, event_done_nxt;
  logic              transfer_active_r, transfer_active_nxt;

  logic              exec;
  logic [IDX_W-1:0]  half;
  logic [IDX_W-1:0]  count_inc;
  logic [5:0]        cur_bit;
  logic              cur_read;
  logic              cur_level;
  logic              rel_nxt;
  logic [31:0]       read_value;

  function automatic logic [5:0] frame_bit(input logic [IDX_W-1:0] idx);
    logic [IDX_W-1:0] pos;
    pos = idx - PRE_IDX;
    if (idx < PRE_IDX) begin
      return 6'd32;
    end
    if (pos > IDX_W'(31)) begin
      return 6'd0;
    end
    return 6'd31 - {1'b0, pos[4:0]};
  endfunction

  function automatic logic is_released(input logic active, input logic [31:0] sw,
                                       input logic [IDX_W-1:0] idx);
    return active && (sw[29:28] == OPCODE_READ) && (frame_bit(idx) <= 6'd17);
  endfunction

  assign exec = cmd_valid && !res_full;
  assign cmd_pop = exec;
  assign res_push = exec;

  assign half = {mdc_divider_r, 1'b0};
  assign count_inc = (clock_count_r < {IDX_W{1'b1}}) ? clock_count_r + 1'b1 : clock_count_r;
  assign cur_bit = frame_bit(bit_index_r);
  assign cur_read = (shift_word_r[29:28] == OPCODE_READ);
  assign cur_level = (cur_bit == 6'd32) ||
                     is_released(transfer_active_r, shift_word_r, bit_index_r) ||
                     shift_word_r[cur_bit[4:0]];

  always_comb begin
    frame_word_nxt = frame_word_r;
    shift_word_nxt = shift_word_r;
    bit_index_nxt = bit_index_r;
    clock_count_nxt = clock_count_r;
    hold_count_nxt = hold_count_r;
    mdc_state_nxt = mdc_state_r;
    line_out_nxt = line_out_r;
    event_done_nxt = event_done_r;
    transfer_active_nxt = transfer_active_r;
    read_value = '0;
    case (cmd.op)
      OP_RD_FRAME: begin
        read_value = frame_word_r;
      end
      OP_RD_EVENT: begin
        read_value = 32'(event_done_r) << EVENT_DONE_BIT;
      end
      OP_WR_FRAME: begin
        if (!transfer_active_r) begin
          frame_word_nxt = cmd.data;
          shift_word_nxt = cmd.data;
          bit_index_nxt = '0;
          clock_count_nxt = '0;
          hold_count_nxt = hold_ticks_r;
          mdc_state_nxt = 1'b0;
          transfer_active_nxt = 1'b1;
        end
      end
      OP_CLR_EVENT: begin
        event_done_nxt = 1'b0;
      end
      OP_TICK: begin
        if (transfer_active_r && (mdc_divider_r != '0)) begin
          clock_count_nxt = count_inc;
          if (!mdc_state_r) begin
            if (count_inc >= IDX_W'(hold_count_r) + 1'b1) begin
              line_out_nxt = cur_level;
            end
            if (count_inc >= half) begin
              line_out_nxt = cur_level;
              mdc_state_nxt = 1'b1;
              clock_count_nxt = '0;
              if (cur_read && (cur_bit <= 6'd15)) begin
                frame_word_nxt[15:0] = {frame_word_r[14:0], cmd.mdio_in};
              end
            end
          end else if (count_inc >= half) begin
            mdc_state_nxt = 1'b0;
            clock_count_nxt = '0;
            hold_count_nxt = hold_ticks_r;
            bit_index_nxt = bit_index_r + 1'b1;
            if ({1'b0, bit_index_r} + 1'b1 >= END_IDX) begin
              transfer_active_nxt = 1'b0;
              event_done_nxt = 1'b1;
              bit_index_nxt = '0;
              line_out_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign rel_nxt = is_released(transfer_active_nxt, shift_word_nxt, bit_index_nxt);

  always_comb begin
    res.read_data = read_value;
    res.mdc_level = mdc_state_nxt;
    res.mdio_drive = rel_nxt || line_out_nxt;
    res.mdio_enable = transfer_active_nxt && !rel_nxt;
    res.done_event = event_done_nxt;
    res.busy_flag = transfer_active_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mdc_divider_r <= '0;
      hold_ticks_r <= '0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        CFG_MDC_DIVIDER: mdc_divider_r <= cfg_data[DIV_W-1:0];
        CFG_HOLD_TICKS: hold_ticks_r <= cfg_data[HOLD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_word_r <= '0;
      shift_word_r <= '0;
      bit_index_r <= '0;
      clock_count_r <= '0;
      hold_count_r <= '0;
      mdc_state_r <= 1'b0;
      line_out_r <= 1'b1;
      event_done_r <= 1'b0;
      transfer_active_r <= 1'b0;
    end else if (exec) begin
      frame_word_r <= frame_word_nxt;
      shift_word_r <= shift_word_nxt;
      bit_index_r <= bit_index_nxt;
      clock_count_r <= clock_count_nxt;
      hold_count_r <= hold_count_nxt;
      mdc_state_r <= mdc_state_nxt;
      line_out_r <= line_out_nxt;
      event_done_r <= event_done_nxt;
      transfer_active_r <= transfer_active_nxt;
    end
  end

`ifndef SYNTHESIS
  a_idle_index: assert property (@(posedge clk) disable iff (!rst_n)
    !transfer_active_r |-> (bit_index_r == '0))
    else $error("bit index not cleared while idle");

  a_mdc_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    mdc_state_r |-> transfer_active_r)
    else $error("MDC high without an active transfer");

  a_done_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(event_done_r) |-> $fell(transfer_active_r))
    else $error("done event set other than at frame end");

  a_hold_when_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    !exec |=> ($stable(bit_index_r) && $stable(transfer_active_r)))
    else $error("transfer state moved without a command");
`endif

endmodule

`default_nettype wire

/* rtl/mdio_management_master.sv */
// Top level of the MDIO management master: request queue, classifier, executor, result queue.
// Depends on mmm_pkg, mmm_fifo, mmm_front and mmm_back.
//
// Every request (bus read, bus write or one MDC divider tick) yields exactly one result,
// which carries the read value and the pin and flag state after that request. The block
// takes one request per clock cycle while the command queue is not full and delivers one
// result per cycle while the result queue is not empty; a request is registered in the
// command queue, executes combinationally and its result is registered in the result queue.
// The two queues hold CMD_DEPTH and OUT_DEPTH entries and let either side stall independently.
// Configuration writes take effect for the next executed request and belong in idle periods.
`timescale 1ns / 1ps
`default_nettype none

module mdio_management_master #(
  parameter int PREAMBLE_BITS = 32,
  parameter int CMD_DEPTH = 2,
  parameter int OUT_DEPTH = 2
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_push,
  output logic                                in_full,
  input  wire mmm_pkg::in_item_t              in_item,
  output logic                                out_empty,
  input  wire logic                           out_pop,
  output mmm_pkg::out_item_t                  out_item,
  input  wire logic                           cfg_wr_en,
  input  wire logic                           cfg_index,
  input  wire logic [mmm_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mmm_pkg::*;

  cmd_t      front_cmd;
  cmd_t      queued_cmd;
  logic      cmd_empty;
  logic      cmd_pop;
  logic      res_full;
  logic      res_push;
  out_item_t res;

  mmm_front u_front (
    .item (in_item),
    .cmd  (front_cmd)
  );

  mmm_fifo #(
    .WIDTH ($bits(cmd_t)),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (in_push),
    .wr_data (front_cmd),
    .full    (in_full),
    .pop     (cmd_pop),
    .rd_data (queued_cmd),
    .empty   (cmd_empty)
  );

  mmm_back #(
    .PREAMBLE_BITS (PREAMBLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (!cmd_empty),
    .cmd       (queued_cmd),
    .cmd_pop   (cmd_pop),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res)
  );

  mmm_fifo #(
    .WIDTH ($bits(out_item_t)),
    .DEPTH (OUT_DEPTH)
  ) u_out_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (out_item),
    .empty   (out_empty)
  );

endmodule

`default_nettype wire
